// ----- sv/mpq_pkg.sv -----
// ---------------------------------------------------------------------------
// mpq_pkg - shared types and codes of the max priority queue
// Operation kinds, status codes, sequencer states and scan control word.
// ---------------------------------------------------------------------------
package mpq_pkg;

  // operation kinds carried in the input word
  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_PEEK   = 2'd1;
  localparam logic [1:0] KIND_REMOVE = 2'd2;

  // result status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SETTLE,
    S_FINISH
  } mpq_state_t;

  // control word from the sequencer to the scan unit
  typedef struct packed {
    logic en;
    logic first;
    logic signed_order;
  } mpq_scan_ctl_t;

endpackage

// ----- sv/mpq_scan.sv -----
// ---------------------------------------------------------------------------
// mpq_scan - running maximum over a stream of store entries
// One comparator, used once per entry, keeps the first greatest value seen
// and its position in the store.
// ---------------------------------------------------------------------------
module mpq_scan
  import mpq_pkg::*;
#(
  parameter int VALUE_BITS = 32,
  parameter int IDX_BITS   = 4
) (
  input  logic                  clk,
  input  mpq_scan_ctl_t         ctl,
  input  logic [VALUE_BITS-1:0] data,
  input  logic [IDX_BITS-1:0]   idx,
  output logic [VALUE_BITS-1:0] best_value,
  output logic [IDX_BITS-1:0]   best_idx
);

  localparam logic [VALUE_BITS-1:0] SIGN_BIT = {1'b1, {(VALUE_BITS-1){1'b0}}};

  logic [VALUE_BITS-1:0] best_value_r;
  logic [IDX_BITS-1:0]   best_idx_r;
  logic [VALUE_BITS-1:0] cmp_a;
  logic [VALUE_BITS-1:0] cmp_b;
  logic                  above;

  // flip the sign bit so that signed order becomes unsigned order
  always_comb begin
    cmp_a = ctl.signed_order ? (data ^ SIGN_BIT) : data;
    cmp_b = ctl.signed_order ? (best_value_r ^ SIGN_BIT) : best_value_r;
    above = cmp_a > cmp_b;
  end

  // take the first entry, then only a strictly greater one
  always_ff @(posedge clk) begin
    if (ctl.en && (ctl.first || above)) begin
      best_value_r <= data;
      best_idx_r   <= idx;
    end
  end

  assign best_value = best_value_r;
  assign best_idx   = best_idx_r;

endmodule

// ----- sv/max_priority_queue_unit.sv -----
// Insert, kind 3 and peek/remove on an empty store go from the accept straight to
// the finish state. Peek and remove: the scan reads one store entry per cycle
// through a single memory read port and one comparator, then settle and finish.
// One item at a time: a new word is taken only after the finish state loads the result word.
// Synchronous active-low reset empties the store (count to zero), selects signed
// order and drops any pending result; store contents stay undefined.
// ---------------------------------------------------------------------------
// max_priority_queue_unit - unsorted-array max priority queue
// Sequencer, entry memory and output register around a shared scan unit.
// ---------------------------------------------------------------------------
module max_priority_queue_unit
  import mpq_pkg::*;
#(
  parameter int CAPACITY   = 16,
  parameter int VALUE_BITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_kind,
  input  logic signed [31:0] in_value,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_max_value,
  output logic [1:0]         out_status,
  output logic [4:0]         out_count,
  // configuration write channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_data
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (VALUE_BITS > 32) ? VALUE_BITS : 32;
  localparam int OW = (CW > 5) ? CW : 5;

  // entry memory
  logic [VALUE_BITS-1:0] mem [CAPACITY];
  logic [VALUE_BITS-1:0] rd_data_r;
  logic                  rd_en;
  logic [IW-1:0]         rd_addr;
  logic                  wr_en;
  logic [IW-1:0]         wr_addr;
  logic [VALUE_BITS-1:0] wr_data;

  // control and working registers
  mpq_state_t            state_r, state_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic                  signed_order_r;
  logic [1:0]            kind_r, kind_nxt;
  logic [IW-1:0]         issue_idx_r, issue_idx_nxt;
  logic [IW-1:0]         data_idx_r, data_idx_nxt;
  logic [VALUE_BITS-1:0] res_max_r, res_max_nxt;
  logic [1:0]            res_status_r, res_status_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_load;
  logic [31:0]           out_max_value_r;
  logic [1:0]            out_status_r;
  logic [4:0]            out_count_r;

  // scan unit link
  mpq_scan_ctl_t         scan_ctl;
  logic [VALUE_BITS-1:0] best_value;
  logic [IW-1:0]         best_idx;

  logic                  last_entry;
  logic [IW-1:0]         last_idx;
  logic [XW-1:0]         max_ext;
  logic [OW-1:0]         count_ext;

  assign last_idx   = IW'(count_r - CW'(1));
  assign last_entry = (data_idx_r == last_idx);

  mpq_scan #(
    .VALUE_BITS (VALUE_BITS),
    .IDX_BITS   (IW)
  ) u_scan (
    .clk        (clk),
    .ctl        (scan_ctl),
    .data       (rd_data_r),
    .idx        (data_idx_r),
    .best_value (best_value),
    .best_idx   (best_idx)
  );

  // sequencer: next state, memory access and result word
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    kind_nxt       = kind_r;
    issue_idx_nxt  = issue_idx_r;
    data_idx_nxt   = data_idx_r;
    res_max_nxt    = res_max_r;
    res_status_nxt = res_status_r;
    rd_en          = 1'b0;
    rd_addr        = issue_idx_r;
    wr_en          = 1'b0;
    wr_addr        = count_r[IW-1:0];
    wr_data        = VALUE_BITS'($unsigned(in_value));
    in_stall       = 1'b1;
    out_load       = 1'b0;
    scan_ctl       = '{en: 1'b0, first: 1'b0, signed_order: signed_order_r};

    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          kind_nxt       = in_kind;
          res_max_nxt    = '0;
          res_status_nxt = STATUS_OK;
          state_nxt      = S_FINISH;
          priority if (in_kind == KIND_INSERT) begin
            if (count_r == CW'(CAPACITY)) begin
              res_status_nxt = STATUS_FULL;
            end else begin
              wr_en     = 1'b1;
              count_nxt = count_r + CW'(1);
            end
          end else if (in_kind == KIND_PEEK || in_kind == KIND_REMOVE) begin
            if (count_r == '0) begin
              res_status_nxt = STATUS_EMPTY;
            end else begin
              // start the scan with entry 0
              rd_en         = 1'b1;
              rd_addr       = '0;
              issue_idx_nxt = IW'(1);
              data_idx_nxt  = '0;
              state_nxt     = S_SCAN;
            end
          end else begin
            // unused kind: report ok and leave the store alone
          end
        end
      end

      S_SCAN: begin
        scan_ctl.en    = 1'b1;
        scan_ctl.first = (data_idx_r == '0);
        if (last_entry) begin
          // hold the last entry in the read register for the move
          state_nxt = S_SETTLE;
        end else begin
          rd_en         = 1'b1;
          issue_idx_nxt = issue_idx_r + IW'(1);
          data_idx_nxt  = data_idx_r + IW'(1);
        end
      end

      S_SETTLE: begin
        res_max_nxt    = best_value;
        res_status_nxt = STATUS_OK;
        if (kind_r == KIND_REMOVE) begin
          // move the last entry into the freed slot
          wr_en     = 1'b1;
          wr_addr   = best_idx;
          wr_data   = rd_data_r;
          count_nxt = count_r - CW'(1);
        end
        state_nxt = S_FINISH;
      end

      S_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output word: hold while stalled, drop once taken
  always_comb begin
    priority if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign max_ext   = XW'(res_max_r);
  assign count_ext = OW'(count_r);

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      signed_order_r <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      signed_order_r <= cfg_data;
    end
  end

  // working and payload registers
  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    issue_idx_r  <= issue_idx_nxt;
    data_idx_r   <= data_idx_nxt;
    res_max_r    <= res_max_nxt;
    res_status_r <= res_status_nxt;
    if (out_load) begin
      out_max_value_r <= max_ext[31:0];
      out_status_r    <= res_status_r;
      out_count_r     <= count_ext[4:0];
    end
  end

  // entry memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign cfg_ready     = 1'b1;
  assign out_valid     = out_valid_r;
  assign out_max_value = out_max_value_r;
  assign out_status    = out_status_r;
  assign out_count     = out_count_r;

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench - max priority queue unit
// Drives insert, peek and remove words through the stall handshake. A local
// model of the unordered store predicts each result word and a checker
// compares every accepted result word field by field in order. Empty and
// full stores, ties, unused kinds and both comparison orders are exercised.
// ---------------------------------------------------------------------------
module testbench
  import mpq_pkg::*;
();

  localparam int QUEUE_DEPTH = 16;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic [31:0] max_value;
    logic [1:0]  status;
    logic [4:0]  count;
  } queue_result_t;

  // receiver stall patterns
  typedef enum logic [1:0] {
    RX_FLOW,
    RX_SPOTTY,
    RX_RUNS
  } rx_pattern_t;

  // random traffic shapes
  typedef enum logic [1:0] {
    MIX_FILL,
    MIX_DRAIN,
    MIX_EVEN
  } traffic_mix_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         in_kind = KIND_INSERT;
  logic signed [31:0] in_value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] out_max_value;
  logic [1:0]         out_status;
  logic [4:0]         out_count;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic               cfg_data = 1'b0;

  // model of the store and its order register
  logic [31:0]   model_entries [QUEUE_DEPTH];
  int unsigned   model_held = 0;
  bit            model_signed = 1'b1;

  queue_result_t awaited_results [$];
  int            mismatches = 0;
  int            burst_left = 0;

  // receiver pattern state
  rx_pattern_t   rx_pattern = RX_FLOW;
  int            rx_cycles = 0;
  int            stall_left = 0;
  bit            stall_level = 1'b0;

  max_priority_queue_unit #(
    .CAPACITY  (QUEUE_DEPTH),
    .VALUE_BITS(32)
  ) DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_kind      (in_kind),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_max_value(out_max_value),
    .out_status   (out_status),
    .out_count    (out_count),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Strict ordering under the current comparison order
  function automatic bit ranks_above(logic [31:0] a, logic [31:0] b);
    if (model_signed) return $signed(a) > $signed(b);
    return a > b;
  endfunction

  // Apply one operation to the model store and return its result word
  function automatic queue_result_t predict_queue_op(logic [1:0] kind, logic [31:0] value);
    queue_result_t r;
    int unsigned   best;
    r.max_value = '0;
    r.status    = STATUS_OK;
    case (kind)
      KIND_INSERT: begin
        if (model_held >= QUEUE_DEPTH) begin
          r.status = STATUS_FULL;
        end else begin
          model_entries[model_held] = value;
          model_held++;
        end
      end
      KIND_PEEK, KIND_REMOVE: begin
        if (model_held == 0) begin
          r.status = STATUS_EMPTY;
        end else begin
          // first greatest entry wins a tie
          best = 0;
          for (int unsigned i = 1; i < model_held; i++) begin
            if (ranks_above(model_entries[i], model_entries[best])) best = i;
          end
          r.max_value = model_entries[best];
          if (kind == KIND_REMOVE) begin
            model_held--;
            model_entries[best] = model_entries[model_held];
          end
        end
      end
      default: ;
    endcase
    r.count = model_held[4:0];
    return r;
  endfunction

  // Offer one word, holding it until accepted; idle between bursts
  task automatic send_word(input logic [1:0] kind, input logic [31:0] value);
    int gap;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 20);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 250)
                                               : $urandom_range(1, 30);
    end
    in_valid <= 1'b1;
    in_kind  <= kind;
    in_value <= value;
    do @(posedge clk); while (in_stall);
    awaited_results.push_back(predict_queue_op(kind, value));
    burst_left--;
  endtask

  // Stop sending and wait for every awaited result word
  task automatic wait_for_results();
    in_valid <= 1'b0;
    burst_left = 0;
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  // Write the order register while the block is idle
  task automatic write_order(input bit use_signed);
    cfg_valid <= 1'b1;
    cfg_data  <= use_signed;
    do @(posedge clk); while (!cfg_ready);
    model_signed = use_signed;
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] random_value();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 7);
      1: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      2: return 32'h8000_0000 ^ $urandom_range(0, 15);
      3: return 32'hFFFF_FFFF - $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [1:0] random_kind(traffic_mix_t mix);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 3) return KIND_UNUSED;
    case (mix)
      MIX_FILL:  return (roll < 80) ? KIND_INSERT : (roll < 90) ? KIND_PEEK : KIND_REMOVE;
      MIX_DRAIN: return (roll < 15) ? KIND_INSERT : (roll < 35) ? KIND_PEEK : KIND_REMOVE;
      default:   return (roll < 45) ? KIND_INSERT : (roll < 65) ? KIND_PEEK : KIND_REMOVE;
    endcase
  endfunction

  // Peek and remove on an empty store, plus the unused kind
  task automatic test_empty_store();
    send_word(KIND_PEEK, 32'hFFFF_FFFF);
    send_word(KIND_REMOVE, 32'h1234_5678);
    send_word(KIND_UNUSED, 32'hFFFF_FFFF);
  endtask

  // Fill with extremes and ties, overflow, then peek and remove
  task automatic test_fill_and_overflow();
    logic [31:0] fill_values [QUEUE_DEPTH];
    fill_values = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
                    32'h0000_0005, 32'h0000_0005, 32'h7FFF_FFFF, 32'h8000_0000,
                    32'h0000_0001, 32'hAAAA_AAAA, 32'h5555_5555, 32'h7FFF_FFFE,
                    32'h8000_0001, 32'h0000_0005, 32'hFFFF_FFFE, 32'h7FFF_FFFF};
    foreach (fill_values[i]) send_word(KIND_INSERT, fill_values[i]);
    send_word(KIND_INSERT, 32'h1234_5678);
    send_word(KIND_PEEK, 32'h0);
    send_word(KIND_REMOVE, 32'h0);
    send_word(KIND_UNUSED, 32'h0);
  endtask

  // Random sequences under one comparison order
  task automatic test_random_traffic(input bit use_signed, input int n_items);
    traffic_mix_t mix;
    logic [1:0]   kind;
    int           run;
    int           sent;
    wait_for_results();
    write_order(use_signed);
    sent = 0;
    while (sent < n_items) begin
      mix = traffic_mix_t'($urandom_range(0, 2));
      run = $urandom_range(4, 40);
      repeat (run) begin
        kind = random_kind(mix);
        send_word(kind, random_value());
        if (kind != KIND_UNUSED) sent++;
      end
    end
  endtask

  // Compare one accepted result word with the oldest expectation
  task automatic check_result_word();
    queue_result_t want;
    queue_result_t got;
    got = '{out_max_value, out_status, out_count};
    if (awaited_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: unexpected result word max=%h status=%0d count=%0d",
                 $realtime, got.max_value, got.status, got.count);
      return;
    end
    want = awaited_results.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: result mismatch max=%h/%h status=%0d/%0d count=%0d/%0d (exp/act)",
                 $realtime, want.max_value, got.max_value, want.status, got.status,
                 want.count, got.count);
    end
  endtask

  // Check accepted words and advance the receiver stall pattern
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_result_word();
    rx_cycles++;
    if (rx_cycles % 1500 == 0) rx_pattern = rx_pattern_t'($urandom_range(0, 2));
    if (stall_left > 0) begin
      stall_left--;
    end else begin
      case (rx_pattern)
        RX_FLOW: begin
          stall_level = 1'b0;
          stall_left  = $urandom_range(5, 40);
        end
        RX_SPOTTY: begin
          stall_level = ($urandom_range(0, 2) == 0);
        end
        default: begin
          stall_level = ~stall_level;
          stall_left  = $urandom_range(1, 24);
        end
      endcase
    end
    out_stall <= stall_level;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_store();
    test_fill_and_overflow();
    test_random_traffic(1'b0, 340);
    test_random_traffic(1'b1, 340);
    test_random_traffic(1'b0, 340);
    test_random_traffic(1'b1, 340);
    wait_for_results();
    // catch any stray result words
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #(10_000_000);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
